### rtl/ptts_pkg.sv
// ----------------------------------------------------------------------------
// ptts_pkg
// Shared types and codes of the periodic task tick scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package ptts_pkg;

  // Request kinds
  localparam logic KIND_CREATE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  // Create status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_SLOT  = 2'd1;
  localparam logic [1:0] ST_NULL_TASK = 2'd2;
  localparam logic [1:0] ST_TAKEN     = 2'd3;

  // Field widths
  localparam int SLOT_W   = 8;
  localparam int PERIOD_W = 16;
  localparam int DELAY_W  = 8;
  localparam int STATUS_W = 2;
  localparam int FSLOT_W  = 3;

  // Fires reported per tick
  localparam int MAX_RESULTS = 8;
  localparam int FIRE_CNT_W  = $clog2(MAX_RESULTS + 1);

  // Controller to datapath commands
  typedef struct packed {
    logic create;       // accepted create word: check, write, capture status
    logic tick_start;   // accepted tick word: rewind the walk
    logic walk;         // walk the slot table
    logic emit_create;  // load the create reply into the output register
    logic emit_final;   // load the final tick result into the output register
  } ptts_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic walk_done;    // every slot read and processed
    logic out_free;     // output register can take a word this cycle
  } ptts_stat_t;

endpackage

`default_nettype wire

### rtl/ptts_req_if.sv
// ----------------------------------------------------------------------------
// ptts_req_if
// Request channel: create and tick words with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptts_req_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [ptts_pkg::SLOT_W-1:0]   slot;
  logic                          handle_valid;
  logic [ptts_pkg::PERIOD_W-1:0] period;
  logic [ptts_pkg::DELAY_W-1:0]  first_delay;

  modport source (output valid, kind, slot, handle_valid, period, first_delay,
                  input ready);
  modport sink   (input valid, kind, slot, handle_valid, period, first_delay,
                  output ready);
endinterface

`default_nettype wire

### rtl/ptts_rsp_if.sv
// ----------------------------------------------------------------------------
// ptts_rsp_if
// Response channel: create replies and tick results with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptts_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          reply_kind;
  logic [ptts_pkg::STATUS_W-1:0] status;
  logic                          fired;
  logic [ptts_pkg::FSLOT_W-1:0]  fired_slot;
  logic                          last;

  modport source (output valid, reply_kind, status, fired, fired_slot, last,
                  input ready);
  modport sink   (input valid, reply_kind, status, fired, fired_slot, last,
                  output ready);
endinterface

`default_nettype wire

### rtl/ptts_ctrl.sv
// ----------------------------------------------------------------------------
// ptts_ctrl
// Sequencer: takes one request word at a time and steps the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module ptts_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  input  wire logic                 req_kind,
  output logic                      req_ready,
  input  wire ptts_pkg::ptts_stat_t stat,
  output ptts_pkg::ptts_cmd_t       cmd
);
  import ptts_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CREATE = 2'd1;
  localparam logic [1:0] S_WALK   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;

  always_comb begin
    cmd.create      = accept && (req_kind == KIND_CREATE);
    cmd.tick_start  = accept && (req_kind == KIND_TICK);
    cmd.walk        = (state == S_WALK);
    cmd.emit_create = (state == S_CREATE) && stat.out_free;
    cmd.emit_final  = (state == S_FINISH) && stat.out_free;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (req_kind == KIND_CREATE) ? S_CREATE : S_WALK;
        end
      end
      S_CREATE: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      S_WALK: begin
        if (stat.walk_done) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### rtl/ptts_dpath.sv
// ----------------------------------------------------------------------------
// ptts_dpath
// Slot table, countdown walk pipeline, pending fire and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptts_dpath #(
  parameter int NUM_SLOTS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ptts_pkg::ptts_cmd_t           cmd,
  input  wire logic [ptts_pkg::SLOT_W-1:0]   slot,
  input  wire logic                          handle_valid,
  input  wire logic [ptts_pkg::PERIOD_W-1:0] period,
  input  wire logic [ptts_pkg::DELAY_W-1:0]  first_delay,
  output ptts_pkg::ptts_stat_t               stat,
  output logic                               rsp_valid,
  input  wire logic                          rsp_ready,
  output logic                               rsp_reply_kind,
  output logic [ptts_pkg::STATUS_W-1:0]      rsp_status,
  output logic                               rsp_fired,
  output logic [ptts_pkg::FSLOT_W-1:0]       rsp_fired_slot,
  output logic                               rsp_last
);
  import ptts_pkg::*;

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);

  // Slot table
  logic [NUM_SLOTS-1:0] slot_valid;
  logic [PERIOD_W-1:0]  per_mem [NUM_SLOTS];
  logic [PERIOD_W-1:0]  cnt_mem [NUM_SLOTS];

  // Create path
  logic [IW-1:0]       cr_idx;
  logic [STATUS_W-1:0] cr_status;
  logic [STATUS_W-1:0] status_q;

  // Walk pipeline
  logic [CW-1:0]         rd_cnt;
  logic                  issue;
  logic                  s1_vld;
  logic [IW-1:0]         s1_idx;
  logic [IW+FSLOT_W-1:0] s1_idx_ext;
  logic [PERIOD_W-1:0]   per_q;
  logic [PERIOD_W-1:0]   cnt_q;
  logic                  s1_live;
  logic                  s1_zero;
  logic                  fire_rep;
  logic                  stall;
  logic                  s1_go;
  logic [FIRE_CNT_W-1:0] fire_n;

  // Pending fire and output
  logic               pend_vld;
  logic [FSLOT_W-1:0] pend_slot;
  logic               out_free;
  logic               push;

  assign cr_idx = slot[IW-1:0];

  always_comb begin
    if ({1'b0, slot} >= (SLOT_W + 1)'(NUM_SLOTS)) begin
      cr_status = ST_BAD_SLOT;
    end else if (!handle_valid) begin
      cr_status = ST_NULL_TASK;
    end else if (slot_valid[cr_idx]) begin
      cr_status = ST_TAKEN;
    end else begin
      cr_status = ST_OK;
    end
  end

  assign out_free = !rsp_valid || rsp_ready;

  assign s1_live    = s1_vld && slot_valid[s1_idx];
  assign s1_zero    = (cnt_q == '0);
  assign fire_rep   = cmd.walk && s1_live && s1_zero
                      && (fire_n < FIRE_CNT_W'(MAX_RESULTS));
  assign stall      = fire_rep && pend_vld && !out_free;
  assign s1_go      = cmd.walk && s1_live && !stall;
  assign issue      = cmd.walk && !stall && (rd_cnt != CW'(NUM_SLOTS));
  assign push       = fire_rep && !stall && pend_vld;
  assign s1_idx_ext = (IW + FSLOT_W)'(s1_idx);

  assign stat.walk_done = (rd_cnt == CW'(NUM_SLOTS)) && !s1_vld;
  assign stat.out_free  = out_free;

  // Table memories: one read address, registered read data
  always_ff @(posedge clk) begin
    if (issue) begin
      per_q <= per_mem[rd_cnt[IW-1:0]];
      cnt_q <= cnt_mem[rd_cnt[IW-1:0]];
    end
    if (cmd.create && (cr_status == ST_OK)) begin
      per_mem[cr_idx] <= period;
      cnt_mem[cr_idx] <= PERIOD_W'(first_delay);
    end else if (s1_go) begin
      cnt_mem[s1_idx] <= s1_zero ? per_q : PERIOD_W'(cnt_q - PERIOD_W'(1));
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      rd_cnt     <= '0;
      s1_vld     <= 1'b0;
      fire_n     <= '0;
      pend_vld   <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cmd.create && (cr_status == ST_OK)) begin
        slot_valid[cr_idx] <= 1'b1;
      end
      if (cmd.tick_start) begin
        rd_cnt <= '0;
        fire_n <= '0;
      end else begin
        if (issue) rd_cnt <= CW'(rd_cnt + CW'(1));
        if (fire_rep && !stall) fire_n <= FIRE_CNT_W'(fire_n + FIRE_CNT_W'(1));
      end
      if (cmd.walk && !stall) begin
        s1_vld <= issue;
      end
      if (fire_rep && !stall) begin
        pend_vld <= 1'b1;
      end else if (cmd.emit_final) begin
        pend_vld <= 1'b0;
      end
      if (push || cmd.emit_create || cmd.emit_final) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (cmd.create) begin
      status_q <= cr_status;
    end
    if (cmd.walk && !stall) begin
      s1_idx <= rd_cnt[IW-1:0];
    end
    if (fire_rep && !stall) begin
      pend_slot <= s1_idx_ext[FSLOT_W-1:0];
    end
    if (push) begin
      rsp_reply_kind <= KIND_TICK;
      rsp_status     <= ST_OK;
      rsp_fired      <= 1'b1;
      rsp_fired_slot <= pend_slot;
      rsp_last       <= 1'b0;
    end else if (cmd.emit_create) begin
      rsp_reply_kind <= KIND_CREATE;
      rsp_status     <= status_q;
      rsp_fired      <= 1'b0;
      rsp_fired_slot <= '0;
      rsp_last       <= 1'b1;
    end else if (cmd.emit_final) begin
      rsp_reply_kind <= KIND_TICK;
      rsp_status     <= ST_OK;
      rsp_fired      <= pend_vld;
      rsp_fired_slot <= pend_vld ? pend_slot : '0;
      rsp_last       <= 1'b1;
    end
  end

endmodule

`default_nettype wire

### rtl/periodic_task_tick_scheduler_core.sv
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler_core
// Time-triggered cooperative task scheduler with a priority-indexed slot table.
// ----------------------------------------------------------------------------
// The block keeps NUM_SLOTS task slots. A create word (kind 0) claims a slot
// with a period and a first delay and gets one status reply: ok, bad slot,
// null task or slot taken. A tick word (kind 1) walks every slot in index
// order; a valid slot whose countdown is zero fires and reloads its period,
// any other valid slot counts down. Each firing slot gives one result word,
// the final one marked last; a tick with no fire gives one non-fire word
// marked last. At most eight fires are reported per tick, though every slot
// still reloads. Requests are taken one at a time. A create checks and
// writes the slot on accept, then loads its reply. A tick accepts the word,
// reads the slots in turn, finishes the last slot, sees the walk done and
// loads the final word. The period and countdown tables sit in a memory with
// one read port, read one slot per cycle while the walk is not paused, with
// a registered read, and written back after the read. The walk pauses when
// a second fire is found while the response channel still holds a word.
// Valid marks are flip-flops cleared by reset, so there is no clearing pass
// and the block takes requests right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_task_tick_scheduler_core #(
  parameter int NUM_SLOTS = 8
) (
  input wire logic clk,
  input wire logic rst,
  ptts_req_if.sink   req,
  ptts_rsp_if.source rsp
);
  import ptts_pkg::*;

  ptts_cmd_t  cmd;
  ptts_stat_t stat;

  // Sequencer: owns the request handshake
  ptts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_kind  (req.kind),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: slot table, walk and the response register
  ptts_dpath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .slot           (req.slot),
    .handle_valid   (req.handle_valid),
    .period         (req.period),
    .first_delay    (req.first_delay),
    .stat           (stat),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_reply_kind (rsp.reply_kind),
    .rsp_status     (rsp.status),
    .rsp_fired      (rsp.fired),
    .rsp_fired_slot (rsp.fired_slot),
    .rsp_last       (rsp.last)
  );

  // An accepted word keeps the block busy for at least the next cycle
  a_busy_after_accept : assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while previous one still in flight");

  // Replies load only into a free output register
  a_emit_needs_room : assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_create || cmd.emit_final) |-> stat.out_free)
    else $error("reply loaded over an untaken response word");

  // A create reply is always the sole, final word of its request
  a_create_reply_last : assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.reply_kind == KIND_CREATE) |-> rsp.last && !rsp.fired)
    else $error("create reply not marked last or marked fired");

  // No new request while the walk is still running
  a_walk_blocks_req : assert property (@(posedge clk) disable iff (rst)
    cmd.walk |-> !req.ready)
    else $error("request port open during a tick walk");

endmodule

`default_nettype wire
